// ----- rtl/core/fts_pkg.sv -----
// Package with the widths, limits, codes and types of the temperature statistics block.
`default_nettype none

package fts_pkg;

	localparam int MAX_RECORDS = 65536;
	localparam int TEMP_LIMIT  = 99;

	localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
	localparam int SUM_W  = $clog2(TEMP_LIMIT * MAX_RECORDS + 1) + 1;
	localparam int MAG_W  = SUM_W - 1;
	localparam int DIV_W  = MAG_W + 6;
	localparam int QW     = 10;
	localparam int STEP_W = $clog2(QW);
	localparam int AVG_W  = 11;
	localparam int TEMP_W = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_YEAR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MONTH = 2'd1;

	localparam logic [15:0] YEAR_RESET = 16'd2000;

	localparam logic [7:0] MONTH_MAX  = 8'd12;
	localparam logic [7:0] DAY_MAX    = 8'd31;
	localparam logic [7:0] HOUR_MAX   = 8'd23;
	localparam logic [7:0] MINUTE_MAX = 8'd59;

	localparam logic signed [TEMP_W-1:0] TEMP_HI  = 8'sd99;
	localparam logic signed [TEMP_W-1:0] TEMP_LO  = -8'sd99;
	localparam logic signed [TEMP_W-1:0] MIN_INIT = 8'sd100;
	localparam logic signed [TEMP_W-1:0] MAX_INIT = -8'sd100;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} fts_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} fts_div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/filtered_temperature_statistics.sv -----
// Top level of the filtered temperature statistics block: filter, accumulators and sequencer.
`default_nettype none

// Records are validated, filtered by target year and optional month, and folded into a
// running minimum, maximum, sum and saturating count at one record per cycle while the
// block is idle. A record flagged last closes the batch. If any record matched, the block
// then stops taking records while the rounded mean in tenths is formed by a divider that
// yields one quotient bit per cycle; if none matched, the divider is skipped. The result
// is placed in an output register that the downstream side may take at its own pace.
// While that register still holds an earlier result, the block waits in its last step
// and takes no records until the register is free. The accumulators return to their
// reset values once the result is loaded; the target registers keep their values and
// may be written only while the block is idle.

module filtered_temperature_statistics
	import fts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// Fields from bit 0: rec_year, rec_month, rec_day, rec_hour, rec_minute, temperature.
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// Fields from bit 0: has_data, average_tenths, minimum_temp, maximum_temp,
	// matched_count, count_overflow, then zero fill.
	output logic      [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [15:0] target_year_q;
	logic [3:0]  target_month_q;

	logic signed [SUM_W-1:0]  sum_q;
	logic        [CNT_W-1:0]  cnt_q;
	logic signed [TEMP_W-1:0] min_q;
	logic signed [TEMP_W-1:0] max_q;
	logic                     ovf_q;

	fts_state_t state_q;
	fts_state_t state_d;
	logic       div_start;
	logic       out_load;
	logic       acc_clear;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [15:0]              rec_year;
	logic [7:0]               rec_month;
	logic [7:0]               rec_day;
	logic [7:0]               rec_hour;
	logic [7:0]               rec_minute;
	logic signed [TEMP_W-1:0] temperature;
	logic                     rec_ok;
	logic                     rec_match;
	logic                     accept;

	logic signed [SUM_W-1:0] sum_abs;
	logic        [MAG_W-1:0] mag;
	logic        [DIV_W-1:0] dividend;
	logic        [QW-1:0]    quotient;
	fts_div_stat_t           div_stat;
	logic signed [AVG_W-1:0] avg;
	logic                    has_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_year_q  <= YEAR_RESET;
			target_month_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TARGET_YEAR: begin
					target_year_q <= cfg_data;
				end
				CFG_TARGET_MONTH: begin
					target_month_q <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign rec_year    = s_tdata[15:0];
	assign rec_month   = s_tdata[23:16];
	assign rec_day     = s_tdata[31:24];
	assign rec_hour    = s_tdata[39:32];
	assign rec_minute  = s_tdata[47:40];
	assign temperature = s_tdata[55:48];

	assign rec_ok = (rec_month != '0) && (rec_month <= MONTH_MAX) &&
		(rec_day != '0) && (rec_day <= DAY_MAX) &&
		(rec_hour <= HOUR_MAX) && (rec_minute <= MINUTE_MAX) &&
		(temperature >= TEMP_LO) && (temperature <= TEMP_HI);
	assign rec_match = rec_ok && (rec_year == target_year_q) &&
		((target_month_q == '0) || (rec_month == {4'b0000, target_month_q}));

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			min_q <= MIN_INIT;
			max_q <= MAX_INIT;
			ovf_q <= 1'b0;
		end else if (acc_clear) begin
			sum_q <= '0;
			cnt_q <= '0;
			min_q <= MIN_INIT;
			max_q <= MAX_INIT;
			ovf_q <= 1'b0;
		end else if (accept && rec_match) begin
			if (cnt_q == CNT_W'(MAX_RECORDS)) begin
				ovf_q <= 1'b1;
			end else begin
				if (temperature < min_q) begin
					min_q <= temperature;
				end
				if (temperature > max_q) begin
					max_q <= temperature;
				end
				sum_q <= sum_q + SUM_W'(temperature);
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// The divider forms (20*|sum| + count) / (2*count), which rounds ties away from zero.
	assign sum_abs  = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign mag      = sum_abs[MAG_W-1:0];
	assign dividend = DIV_W'({mag, 4'b0000}) + DIV_W'({mag, 2'b00}) + DIV_W'(cnt_q);

	fts_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  ({cnt_q, 1'b0}),
		.quotient (quotient),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		acc_clear = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && s_tlast) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (cnt_q != '0) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load  = 1'b1;
					acc_clear = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign has_data = (cnt_q != '0);
	assign avg      = sum_q[SUM_W-1] ? -AVG_W'(quotient) : AVG_W'(quotient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (has_data) begin
				out_data_q <= OUT_DATA_W'({ovf_q, cnt_q, max_q, min_q, avg, 1'b1});
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		(div_stat.busy || div_stat.done) |-> (state_q == ST_DIV))
		else $error("divider active outside the divide state");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RECORDS))
		else $error("matched count beyond capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == CNT_W'(MAX_RECORDS)))
		else $error("overflow flagged before the count is full");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (min_q <= max_q))
		else $error("minimum above maximum with data present");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/fts_divider.sv -----
// Restoring divider that produces one quotient bit per cycle for the rounded mean.
`default_nettype none

module fts_divider
	import fts_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [CNT_W:0]   divisor,
	output logic      [QW-1:0]    quotient,
	output fts_div_stat_t         stat
);

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsh_q;
	logic [QW-1:0]     quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QW - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= DIV_W'({divisor, {(QW - 1){1'b0}}});
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QW-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ----- dv/filtered_temperature_statistics_checker.sv -----
// Checker that predicts the statistics results of the temperature block and compares them.
`default_nettype none

module filtered_temperature_statistics_checker
	import fts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tlast,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending_results,
	output int                         results_checked,
	output int                         records_taken,
	output int                         records_matched
);

	// Members run from the top bit down, so has_data lands in bit 0 as on m_tdata.
	typedef struct packed {
		logic                     ovf;
		logic [CNT_W-1:0]         count;
		logic signed [TEMP_W-1:0] max_t;
		logic signed [TEMP_W-1:0] min_t;
		logic signed [AVG_W-1:0]  avg;
		logic                     has_data;
	} batch_stats_t;

	logic [15:0]  tgt_year;
	logic [3:0]   tgt_month;
	longint       acc_sum;
	int           acc_count;
	int           acc_min;
	int           acc_max;
	logic         acc_ovf;
	batch_stats_t expected_stats_q[$];

	task automatic clear_acc();
		acc_sum   = 0;
		acc_count = 0;
		acc_min   = int'(MIN_INIT);
		acc_max   = int'(MAX_INIT);
		acc_ovf   = 1'b0;
	endtask

	task automatic fold_record(input logic [IN_DATA_W-1:0] d, input logic last);
		logic [15:0]              yr;
		logic [7:0]               mo;
		logic [7:0]               dy;
		logic [7:0]               hr;
		logic [7:0]               mi;
		logic signed [TEMP_W-1:0] t;
		logic                     ok;
		logic                     hit;
		longint                   mag;
		longint                   q;
		longint                   avg;
		batch_stats_t             stats;
		yr = d[15:0];
		mo = d[23:16];
		dy = d[31:24];
		hr = d[39:32];
		mi = d[47:40];
		t  = d[55:48];
		ok = mo >= 8'd1 && mo <= MONTH_MAX && dy >= 8'd1 && dy <= DAY_MAX &&
		     hr <= HOUR_MAX && mi <= MINUTE_MAX && t >= TEMP_LO && t <= TEMP_HI;
		hit = ok && yr == tgt_year && (tgt_month == 4'd0 || mo == {4'd0, tgt_month});
		records_taken++;
		if (hit) begin
			records_matched++;
			if (acc_count >= MAX_RECORDS) begin
				acc_ovf = 1'b1;
			end else begin
				if (int'(t) < acc_min) acc_min = int'(t);
				if (int'(t) > acc_max) acc_max = int'(t);
				acc_sum += int'(t);
				acc_count++;
			end
		end
		if (last) begin
			stats = '0;
			if (acc_count != 0) begin
				mag = (acc_sum < 0 ? -acc_sum : acc_sum) * 10;
				q   = (2 * mag + acc_count) / (2 * longint'(acc_count));
				avg = acc_sum < 0 ? -q : q;
				stats.has_data = 1'b1;
				stats.avg      = avg[AVG_W-1:0];
				stats.min_t    = acc_min[TEMP_W-1:0];
				stats.max_t    = acc_max[TEMP_W-1:0];
				stats.count    = acc_count[CNT_W-1:0];
				stats.ovf      = acc_ovf;
			end
			expected_stats_q.push_back(stats);
			clear_acc();
		end
	endtask

	task automatic compare_field(input string fname, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", fname, want, got);
			fail_count++;
		end
	endtask

	task automatic check_stats(input logic [OUT_DATA_W-1:0] d);
		batch_stats_t want;
		batch_stats_t got;
		got = d[$bits(batch_stats_t)-1:0];
		if (expected_stats_q.size() == 0) begin
			$error("statistics item arrived with no batch outstanding");
			fail_count++;
		end else begin
			want = expected_stats_q.pop_front();
			compare_field("has_data", longint'(want.has_data), longint'(got.has_data));
			compare_field("average_tenths", longint'(want.avg), longint'(got.avg));
			compare_field("minimum_temp", longint'(want.min_t), longint'(got.min_t));
			compare_field("maximum_temp", longint'(want.max_t), longint'(got.max_t));
			compare_field("matched_count", longint'(want.count), longint'(got.count));
			compare_field("count_overflow", longint'(want.ovf), longint'(got.ovf));
			results_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_year  = YEAR_RESET;
			tgt_month = 4'd0;
			clear_acc();
			expected_stats_q.delete();
			fail_count      = 0;
			pending_results = 0;
			results_checked = 0;
			records_taken   = 0;
			records_matched = 0;
		end else begin
			if (m_tvalid && m_tready) check_stats(m_tdata);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TARGET_YEAR) tgt_year = cfg_data;
				else if (cfg_index == CFG_TARGET_MONTH) tgt_month = cfg_data[3:0];
			end
			if (s_tvalid && s_tready) fold_record(s_tdata, s_tlast);
			pending_results = expected_stats_q.size();
		end
	end

endmodule

`default_nettype wire

// ----- dv/filtered_temperature_statistics_tb.sv -----
// Testbench top that drives records and register writes into the temperature block and reports.
`default_nettype none

module filtered_temperature_statistics_tb;
	import fts_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int STALL_CYCLES   = 400;
	localparam int SETTLE_CYCLES  = 32;
	localparam int PHASE_COUNT    = 10;
	localparam int PHASE_RECORDS  = 125;
	localparam int TIMEOUT_UNITS  = 4800000;

	typedef enum int {
		FLAW_NONE,
		FLAW_RANDOM,
		FLAW_MONTH,
		FLAW_DAY,
		FLAW_HOUR,
		FLAW_MINUTE,
		FLAW_TEMP,
		FLAW_YEAR,
		FLAW_OTHER_MONTH
	} flaw_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int pending_results;
	int results_checked;
	int records_taken;
	int records_matched;

	bit          src_idle_on = 1'b0;
	bit          sink_idle_on = 1'b0;
	bit          stall_request = 1'b0;
	logic [15:0] cur_year = YEAR_RESET;
	logic [3:0]  cur_month = 4'd0;
	int          cfg_writes = 0;

	filtered_temperature_statistics dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	filtered_temperature_statistics_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.results_checked (results_checked),
		.records_taken   (records_taken),
		.records_matched (records_matched)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#TIMEOUT_UNITS;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		@(negedge clk);
		forever begin
			if (stall_request) begin
				m_tready <= 1'b0;
				repeat (STALL_CYCLES) @(negedge clk);
				stall_request = 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	task automatic send(input logic [15:0] yr, input logic [7:0] mo, input logic [7:0] dy,
			input logic [7:0] hr, input logic [7:0] mi, input logic [7:0] t,
			input logic last);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {t, mi, hr, dy, mo, yr};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_record(input flaw_t flaw, input logic last);
		logic [15:0] yr;
		logic [7:0]  mo;
		logic [7:0]  dy;
		logic [7:0]  hr;
		logic [7:0]  mi;
		logic [7:0]  t;
		int          r;
		yr = cur_year;
		mo = (cur_month >= 4'd1 && cur_month <= 4'd12) ? {4'd0, cur_month} :
		     8'($urandom_range(1, 12));
		dy = 8'($urandom_range(1, 31));
		hr = 8'($urandom_range(0, 23));
		mi = 8'($urandom_range(0, 59));
		r  = $urandom_range(0, 15);
		t  = r == 0 ? TEMP_LO : r == 1 ? TEMP_HI : 8'(int'($urandom_range(0, 198)) - 99);
		case (flaw)
			FLAW_RANDOM: begin
				yr = 16'($urandom);
				mo = 8'($urandom);
				dy = 8'($urandom);
				hr = 8'($urandom);
				mi = 8'($urandom);
				t  = 8'($urandom);
			end
			FLAW_MONTH:  mo = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(13, 255));
			FLAW_DAY:    dy = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(32, 255));
			FLAW_HOUR:   hr = 8'($urandom_range(24, 255));
			FLAW_MINUTE: mi = 8'($urandom_range(60, 255));
			FLAW_TEMP:   t  = 8'($urandom_range(100, 156));
			FLAW_YEAR:   yr = $urandom_range(0, 1) ? cur_year + 16'd1 : cur_year - 16'd1;
			FLAW_OTHER_MONTH: begin
				mo = 8'($urandom_range(1, 12));
			end
			default: begin
			end
		endcase
		send(yr, mo, dy, hr, mi, t, last);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
		if (idx == CFG_TARGET_YEAR) cur_year = val;
		else if (idx == CFG_TARGET_MONTH) cur_month = val[3:0];
		cfg_writes++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int    phase;
		int    budget;
		int    blen;
		int    n;
		flaw_t flaw;
		logic [3:0] month_sel;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// A batch where nothing matches, then the extremes of every valid field.
		send(16'd2000, 8'd0, 8'd1, 8'd0, 8'd0, 8'sd5, 1'b1);
		send(16'd2000, 8'd1, 8'd1, 8'd0, 8'd0, -8'sd99, 1'b0);
		send(16'd2000, 8'd12, 8'd31, 8'd23, 8'd59, 8'sd99, 1'b0);
		send(16'd2000, 8'd6, 8'd15, 8'd12, 8'd30, 8'sd0, 1'b1);
		// Each way a record can fail validation or the year filter, closed by one good record.
		send(16'd2000, 8'd13, 8'd1, 8'd0, 8'd0, 8'sd10, 1'b0);
		send(16'd2000, 8'd255, 8'd1, 8'd0, 8'd0, 8'sd10, 1'b0);
		send(16'd2000, 8'd5, 8'd0, 8'd0, 8'd0, 8'sd10, 1'b0);
		send(16'd2000, 8'd5, 8'd32, 8'd0, 8'd0, 8'sd10, 1'b0);
		send(16'd2000, 8'd5, 8'd1, 8'd24, 8'd0, 8'sd10, 1'b0);
		send(16'd2000, 8'd5, 8'd1, 8'd0, 8'd60, 8'sd10, 1'b0);
		send(16'd2000, 8'd5, 8'd1, 8'd0, 8'd0, -8'sd100, 1'b0);
		send(16'd2000, 8'd5, 8'd1, 8'd0, 8'd0, 8'sd100, 1'b0);
		send(16'd2000, 8'd5, 8'd1, 8'd0, 8'd0, -8'sd128, 1'b0);
		send(16'd2000, 8'd5, 8'd1, 8'd0, 8'd0, 8'sd127, 1'b0);
		send(16'd1999, 8'd5, 8'd1, 8'd0, 8'd0, 8'sd10, 1'b0);
		send(16'd2001, 8'd5, 8'd1, 8'd0, 8'd0, 8'sd10, 1'b0);
		send(16'd2000, 8'd5, 8'd1, 8'd0, 8'd0, 8'sd1, 1'b1);
		// Means that fall exactly halfway between tenths, positive and negative.
		send(16'd2000, 8'd3, 8'd1, 8'd0, 8'd0, 8'sd1, 1'b0);
		send(16'd2000, 8'd3, 8'd2, 8'd0, 8'd0, 8'sd0, 1'b0);
		send(16'd2000, 8'd3, 8'd3, 8'd0, 8'd0, 8'sd0, 1'b0);
		send(16'd2000, 8'd3, 8'd4, 8'd0, 8'd0, 8'sd0, 1'b1);
		send(16'd2000, 8'd3, 8'd1, 8'd0, 8'd0, -8'sd1, 1'b0);
		send(16'd2000, 8'd3, 8'd2, 8'd0, 8'd0, 8'sd0, 1'b0);
		send(16'd2000, 8'd3, 8'd3, 8'd0, 8'd0, 8'sd0, 1'b0);
		send(16'd2000, 8'd3, 8'd4, 8'd0, 8'd0, 8'sd0, 1'b1);

		// A month filter no valid record can meet, and writes to unused indexes.
		settle();
		write_reg(CFG_TARGET_MONTH, 16'd13);
		write_reg(CFG_SPARE_A, 16'hFFFF);
		write_reg(CFG_SPARE_B, 16'h0001);
		for (n = 0; n < 3; n++) send_record(FLAW_NONE, n == 2);

		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			settle();
			case (phase % 4)
				0: write_reg(CFG_TARGET_YEAR, 16'd0);
				1: write_reg(CFG_TARGET_YEAR, 16'hFFFF);
				2: write_reg(CFG_TARGET_YEAR, YEAR_RESET);
				default: write_reg(CFG_TARGET_YEAR, 16'($urandom));
			endcase
			case (phase % 5)
				0: month_sel = 4'd0;
				1: month_sel = 4'd12;
				2: month_sel = 4'd1;
				3: month_sel = 4'($urandom_range(13, 15));
				default: month_sel = 4'($urandom_range(0, 15));
			endcase
			write_reg(CFG_TARGET_MONTH, {12'($urandom_range(0, 1) ? $urandom : 0), month_sel});
			if (phase % 4 == 3) write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
					16'($urandom));
			if (phase == PHASE_COUNT - 1) begin
				src_idle_on  = 1'b0;
				sink_idle_on = 1'b0;
			end
			if (phase == 3) stall_request = 1'b1;
			budget = PHASE_RECORDS;
			while (budget > 0) begin
				blen = phase == 3 ? $urandom_range(1, 3) : $urandom_range(1, 12);
				for (n = 0; n < blen; n++) begin
					if ($urandom_range(0, 9) < 8) begin
						flaw = FLAW_NONE;
						budget--;
					end else begin
						flaw = flaw_t'($urandom_range(FLAW_RANDOM, FLAW_OTHER_MONTH));
					end
					send_record(flaw, n == blen - 1);
				end
			end
		end

		settle();
		$display("Covered %0d records, %0d of them matched, giving %0d checked results.",
			records_taken, records_matched, results_checked);
		$display("Used %0d register writes, invalid and unmatched records and a long output stall.",
			cfg_writes);
		if (fail_count == 0 && pending_results == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
